FILE: rtl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg: shared types and constants of the escape sequence decoder
// Parse modes, parser state, result beat layout and the escape letter table.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [1:0] MaxDigits = 2'd3;
  localparam int unsigned QueueDepth = 3;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_DIGITS = 2'd2
  } esd_mode_e;

  typedef struct packed {
    esd_mode_e   mode;
    logic [1:0]  count;
    logic [7:0]  value;
  } esd_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esd_beat_t;

  // Map the letter after a backslash to its character; hit low if no match.
  function automatic logic [8:0] esd_simple_escape(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h3F:   r = {1'b1, 8'h3F};
      default: r = {1'b0, 8'd0};
    endcase
    return r;
  endfunction

  function automatic logic esd_is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/esd_step.sv
// ----------------------------------------------------------------------------
// esd_step: one parser step
// From the current state and one raw byte, form the next state and up to two
// decoded beats.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_step
  import esd_pkg::*;
(
  input  esd_state_t  state_i,
  input  logic        skip_dec_i,
  input  logic [7:0]  data_i,
  input  logic        last_i,
  output esd_state_t  state_o,
  output logic [1:0]  count_o,
  output esd_beat_t   beat0_o,
  output esd_beat_t   beat1_o
);

  logic [8:0] esc_lookup;
  logic       is_dig;
  logic [7:0] digit;
  logic [7:0] acc;
  logic [1:0] cnt_inc;

  // Fresh handling of a byte with no escape pending.
  esd_mode_e  fr_mode;
  logic       fr_emit;
  esd_beat_t  fr_beat;

  assign esc_lookup = esd_simple_escape(data_i);
  assign is_dig     = esd_is_digit(data_i);
  assign digit      = data_i - 8'h30;
  assign acc        = {state_i.value[4:0], 3'b000} + {state_i.value[6:0], 1'b0} + digit;
  assign cnt_inc    = state_i.count + 2'd1;

  always_comb begin
    if (data_i == Backslash && !last_i) begin
      fr_mode = MODE_ESC;
      fr_emit = 1'b0;
    end else begin
      fr_mode = MODE_IDLE;
      fr_emit = 1'b1;
    end
    fr_beat = '{data: data_i, last: last_i};
  end

  always_comb begin
    state_o = state_i;
    count_o = 2'd0;
    beat0_o = fr_beat;
    beat1_o = fr_beat;
    unique case (state_i.mode)
      MODE_ESC: begin
        if (esc_lookup[8]) begin
          state_o.mode = MODE_IDLE;
          count_o      = 2'd1;
          beat0_o      = '{data: esc_lookup[7:0], last: last_i};
        end else if (!skip_dec_i && is_dig) begin
          state_o.value = digit;
          if (last_i) begin
            state_o.mode  = MODE_IDLE;
            state_o.count = 2'd0;
            count_o       = 2'd1;
            beat0_o       = '{data: digit, last: 1'b1};
          end else begin
            state_o.mode  = MODE_DIGITS;
            state_o.count = 2'd1;
          end
        end else begin
          // Lone backslash goes out as is, then the byte is taken afresh.
          state_o.mode = fr_mode;
          beat0_o      = '{data: Backslash, last: 1'b0};
          count_o      = fr_emit ? 2'd2 : 2'd1;
        end
      end
      MODE_DIGITS: begin
        if (is_dig) begin
          state_o.value = acc;
          if (cnt_inc >= MaxDigits || cnt_inc == 2'd0 || last_i) begin
            state_o.mode  = MODE_IDLE;
            state_o.count = 2'd0;
            count_o       = 2'd1;
            beat0_o       = '{data: acc, last: last_i};
          end else begin
            state_o.count = cnt_inc;
          end
        end else begin
          state_o.mode  = fr_mode;
          state_o.count = 2'd0;
          beat0_o       = '{data: state_i.value, last: 1'b0};
          count_o       = fr_emit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        // Idle, and the unused mode code treated alike.
        state_o.mode = fr_mode;
        count_o      = fr_emit ? 2'd1 : 2'd0;
        beat0_o      = fr_beat;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder: C-style escape decoding of a byte stream
// Parser state, a one-bit control register and a three-slot result queue.
// ----------------------------------------------------------------------------
// The decoder takes one raw byte per cycle and turns backslash escapes into
// the bytes they stand for: the letter escapes, quotes, backslash and question
// mark, and one to three decimal digits (value modulo 256) unless
// cfg_wdata_i has written skip_decimal_escapes high. An unknown escape leaves
// the backslash in the output and handles the next byte afresh; a dangling
// backslash or digit run at the end of a text is flushed on its last beat.
// An input beat is decoded in the cycle it is accepted and lands in a small
// result queue, so output becomes valid in the cycle after acceptance. The input
// takes a beat every cycle while the queue has room for two more results;
// since one input beat may give two output beats, sustained throughput is one
// input beat per cycle, bounded by the output side at one beat per cycle.
// Write the control register only while the decoder is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  esd_state_t state_q, state_d, step_state;
  logic       skip_dec_q;
  logic [1:0] step_count;
  esd_beat_t  step_beat0, step_beat1;

  esd_beat_t  slot_q [QueueDepth];
  esd_beat_t  slot_d [QueueDepth];
  logic [1:0] fill_q, fill_d;
  logic [1:0] base;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Keep room for the worst case of two results per beat.
  assign in_ready_o  = (fill_q < 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_byte_o  = slot_q[0].data;
  assign out_last_o  = slot_q[0].last;

  esd_step u_step (
    .state_i    (state_q),
    .skip_dec_i (skip_dec_q),
    .data_i     (in_byte_i),
    .last_i     (in_last_i),
    .state_o    (step_state),
    .count_o    (step_count),
    .beat0_o    (step_beat0),
    .beat1_o    (step_beat1)
  );

  // Advance the parser only on an accepted beat.
  assign state_d = in_fire ? step_state : state_q;

  // Queue: shift down on a pop, append new results after what remains.
  assign base = fill_q - {1'b0, out_fire};

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (out_fire) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        slot_d[i] = slot_q[i + 1];
      end
    end
    for (int i = 0; i < QueueDepth; i++) begin
      if (in_fire && step_count != 2'd0 && 2'(i) == base) begin
        slot_d[i] = step_beat0;
      end
      if (in_fire && step_count == 2'd2 && 2'(i) == base + 2'd1) begin
        slot_d[i] = step_beat1;
      end
    end
    fill_d = base + (in_fire ? step_count : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '{mode: MODE_IDLE, count: 2'd0, value: 8'd0};
      skip_dec_q <= 1'b0;
      fill_q     <= 2'd0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        skip_dec_q <= cfg_wdata_i;
      end
    end
  end

  // Payload slots hold data only; the fill count says which are live.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

`ifndef ASSERT_OFF
  // The queue never receives more results than it has free slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ({1'b0, base} + {1'b0, step_count}) <= 3'd3)
    else $error("result queue overflow");

  // A text's final beat always leaves the parser idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last_i |=> state_q.mode == MODE_IDLE)
    else $error("parser not idle after last beat");

  // A pending digit run holds one or two digits, never more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == MODE_DIGITS |-> (state_q.count == 2'd1 || state_q.count == 2'd2))
    else $error("bad digit count");

  // A pop with no new beat drops exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !in_fire |=> fill_q == $past(fill_q) - 2'd1)
    else $error("queue fill mismatch on pop");
`endif

endmodule

`default_nettype wire

FILE: test/tb_escape_sequence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder: self-checking bench for the escape decoder
// Directed rows, then random escaped texts across register settings, with
// random idling on both channels and a running decode model as the checker.
// ----------------------------------------------------------------------------

module tb_escape_sequence_decoder;
  import esd_pkg::*;

  localparam int          PhaseBeats = 200;
  localparam int          CycleLimit = 150000;
  localparam int          SettleGap  = 6;
  localparam logic [7:0]  DigitZero  = 8'h30;
  localparam logic [7:0]  DigitNine  = 8'h39;

  // One row of the directed table: input beat, and optionally a hand-typed
  // expectation that replaces the model's single result for that row.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    logic [7:0] exp_ch;
    logic       exp_last;
  } stim_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  // Decode model state, kept apart from the block.
  esd_mode_e  dec_mode;
  logic [1:0] dec_count;
  logic [7:0] dec_value;
  logic       skip_digits;

  esd_beat_t  awaited_beats[$];
  int         err_count   = 0;
  int         beats_sent  = 0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  bit         quiet       = 1'b0;

  logic [7:0] esc_letters [11] = '{"a", "b", "f", "n", "r", "t", "v",
                                   8'h27, 8'h22, 8'h5C, 8'h3F};

  stim_row_t  directed_rows [25] = '{
    // byte 0 and byte 255 pass straight through
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
    // letter escapes, with and without the last flag
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{"n",   1'b1, 1'b1, 8'h0A, 1'b1},
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{"a",   1'b0, 1'b1, 8'h07, 1'b0},
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h3F, 1'b0, 1'b1, 8'h3F, 1'b0},
    // three digits close the escape; 999 wraps to 231
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{"9",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"9",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"9",   1'b0, 1'b1, 8'hE7, 1'b0},
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{"2",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"5",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"5",   1'b0, 1'b1, 8'hFF, 1'b0},
    // backslash as the last byte flushes itself
    '{8'h5C, 1'b1, 1'b1, 8'h5C, 1'b1},
    // a single pending digit flushed at end of text
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{"7",   1'b1, 1'b1, 8'h07, 1'b1},
    // unknown escape: backslash, then the byte afresh
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{"A",   1'b1, 1'b0, 8'h00, 1'b0},
    // digit run cut short by a new escape
    '{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},
    '{"1",   1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h5C, 1'b0, 1'b1, 8'h01, 1'b0},
    '{"n",   1'b1, 1'b1, 8'h0A, 1'b1}
  };

  escape_sequence_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Decode model
  // --------------------------------------------------------------------------

  function automatic bit is_decimal(input logic [7:0] ch);
    return (ch >= DigitZero) && (ch <= DigitNine);
  endfunction

  // Append one beat to the tail of the awaited list.
  function automatic void expect_beat(input logic [7:0] ch, input logic last);
    esd_beat_t b;
    b = '{data: ch, last: last};
    awaited_beats.insert(awaited_beats.size(), b);
  endfunction

  // Map the byte after a backslash onto its character; hit stays low if the
  // byte names no letter escape.
  function automatic void letter_escape(input logic [7:0] ch, output bit hit,
                                        output logic [7:0] mapped);
    hit    = 1'b1;
    mapped = ch;
    case (ch)
      "a":     mapped = 8'd7;
      "b":     mapped = 8'd8;
      "f":     mapped = 8'd12;
      "n":     mapped = 8'd10;
      "r":     mapped = 8'd13;
      "t":     mapped = 8'd9;
      "v":     mapped = 8'd11;
      8'h27, 8'h22, 8'h5C, 8'h3F: mapped = ch;
      default: hit = 1'b0;
    endcase
  endfunction

  // A byte met with nothing pending: a backslash opens an escape unless the
  // text ends on it, anything else is passed through.
  function automatic void decode_plain(input logic [7:0] ch, input logic last);
    if (ch == Backslash && !last) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_IDLE;
      expect_beat(ch, last);
    end
  endfunction

  // Advance the model by one input beat, queueing the beats it produces.
  function automatic void predict_decode(input logic [7:0] ch, input logic last);
    bit         hit;
    logic [7:0] mapped;
    case (dec_mode)
      MODE_ESC: begin
        letter_escape(ch, hit, mapped);
        if (hit) begin
          dec_mode = MODE_IDLE;
          expect_beat(mapped, last);
        end else if (!skip_digits && is_decimal(ch)) begin
          dec_value = ch - DigitZero;
          dec_count = 2'd1;
          if (last) begin
            dec_mode  = MODE_IDLE;
            dec_count = 2'd0;
            expect_beat(dec_value, 1'b1);
          end else begin
            dec_mode = MODE_DIGITS;
          end
        end else begin
          expect_beat(Backslash, 1'b0);
          decode_plain(ch, last);
        end
      end
      MODE_DIGITS: begin
        if (is_decimal(ch)) begin
          dec_value = dec_value * 8'd10 + (ch - DigitZero);
          dec_count = dec_count + 2'd1;
          // the third digit closes the run at once, as does end of text
          if (dec_count == MaxDigits || dec_count == 2'd0 || last) begin
            dec_mode  = MODE_IDLE;
            dec_count = 2'd0;
            expect_beat(dec_value, last);
          end
        end else begin
          expect_beat(dec_value, 1'b0);
          dec_count = 2'd0;
          decode_plain(ch, last);
        end
      end
      default: decode_plain(ch, last);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one beat, now and then after a short gap; hold it until taken.
  // Valid is only dropped when a gap is inserted, so it never falls and rises
  // within one time step.
  task automatic send_beat(input logic [7:0] ch, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= ch;
    in_last_i  <= last;
    predict_decode(ch, last);
    beats_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Build one text from well-formed escapes with random content, or, now and
  // then, from raw noise, and send it with the last flag on its final byte.
  task automatic send_text();
    logic [7:0] txt[$];
    int         tokens;
    int         n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end else begin
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
        case ($urandom_range(0, 9))
          0, 1, 2: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
          3, 4: begin
            txt.insert(txt.size(), Backslash);
            txt.insert(txt.size(), esc_letters[$urandom_range(0, 10)]);
          end
          5, 6, 7: begin
            // one to four digits, so that runs overflowing three are seen
            txt.insert(txt.size(), Backslash);
            n = $urandom_range(1, 4);
            repeat (n) txt.insert(txt.size(), DigitZero + 8'($urandom_range(0, 9)));
          end
          8: begin
            txt.insert(txt.size(), Backslash);
            txt.insert(txt.size(), 8'($urandom_range(0, 255)));
          end
          default: begin
            txt.insert(txt.size(), Backslash);
            txt.insert(txt.size(), Backslash);
          end
        endcase
      end
      // leave a dangling backslash at the end of some texts
      if ($urandom_range(0, 4) == 0) txt.insert(txt.size(), Backslash);
    end
    foreach (txt[i]) send_beat(txt[i], i == txt.size() - 1);
  endtask

  // Drop valid, let every awaited beat drain and the parser settle, then
  // write the control register.
  task automatic drain_and_write(input logic skip);
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= skip;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    skip_digits = skip;
  endtask

  // --------------------------------------------------------------------------
  // Output side: check each beat taken, then decide readiness for the next
  // cycle, stalling in short bursts.
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    esd_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_beats.size() == 0) begin
          $error("unexpected beat: out_byte %h, out_last %b", out_byte_o, out_last_o);
          err_count++;
        end else begin
          want = awaited_beats.pop_front();
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte_o);
            err_count++;
          end
          if (out_last_o !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_last_o);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Hard stop on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_escape_sequence_decoder: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed table, random phases across both settings,
  // then a final phase with no idling, and the verdict.
  // --------------------------------------------------------------------------

  initial begin
    logic phase_skip [7];
    int   phase_start;

    phase_skip  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    dec_mode    = MODE_IDLE;
    dec_count   = 2'd0;
    dec_value   = 8'd0;
    skip_digits = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table under the reset setting of the register.
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].ch, directed_rows[i].last);
      if (directed_rows[i].typed) begin
        awaited_beats[awaited_beats.size() - 1] =
          '{data: directed_rows[i].exp_ch, last: directed_rows[i].exp_last};
      end
    end

    // Random phases; each ends only where a text ends, on its last beat, so the
    // parser holds no pending escape or digit run across a register write. The
    // middle settings are drawn at random.
    foreach (phase_skip[p]) begin
      if (p == 3 || p == 4) phase_skip[p] = 1'($urandom_range(0, 1));
      if (p == 6) quiet = 1'b1;
      drain_and_write(phase_skip[p]);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PhaseBeats) send_text();
    end

    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_escape_sequence_decoder: clean");
    end else begin
      $display("tb_escape_sequence_decoder: errors");
    end
    $finish;
  end

endmodule
